@@ rtl/lsrc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and state encodings of the line segment clipper.
package lsrc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 16;
    localparam int RECT_BITS  = 16;
    localparam int SIZE_BITS  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RECT_BITS;

    localparam int FXW      = COORD_BITS + FRAC_BITS + 8;
    localparam int IPW      = FXW - FRAC_BITS;
    localparam int LIM_BITS = COORD_BITS + FRAC_BITS + 6;
    localparam int MAGW     = FXW;
    localparam int SLOPEW   = MAGW + FRAC_BITS;
    localparam int ACCW     = SLOPEW + 1;
    localparam int PRODW    = ACCW + MAGW;
    localparam int ADDW     = SLOPEW + 2;
    localparam int CNT_W    = $clog2(SLOPEW);
    localparam int EDGE_W   = RECT_BITS + 2;

    localparam int ITER_MAX = 8;
    localparam int ITER_W   = $clog2(ITER_MAX + 1);

    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(SLOPEW - 1);
    localparam logic [CNT_W-1:0]  MUL_LAST  = CNT_W'(MAGW - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_MAX);

    localparam logic [MAGW-1:0] LIM = MAGW'((64'd1 << LIM_BITS) - 64'd1);

    localparam logic signed [EDGE_W-1:0] EDGE_ONE = EDGE_W'(1);

    localparam logic [SIZE_BITS-1:0] RST_WIDTH  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] RST_HEIGHT = SIZE_BITS'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BOTTOM = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_seg_in;

    typedef struct packed {
        logic                         visible;
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
    } t_seg_out;

    typedef struct packed {
        logic            start;
        logic [MAGW-1:0] num_mag;
        logic [MAGW-1:0] den_mag;
        logic [MAGW-1:0] offs_mag;
    } t_du_req;

    typedef struct packed {
        logic            done;
        logic [MAGW-1:0] step_mag;
    } t_du_rsp;

    typedef enum logic [2:0] {
        CL_IDLE,
        CL_EVAL,
        CL_NUM,
        CL_DEN,
        CL_TDIST,
        CL_CALL,
        CL_WAIT
    } t_cl_state;

    typedef enum logic [1:0] {
        DU_IDLE,
        DU_DIV,
        DU_MUL,
        DU_DONE
    } t_du_state;

endpackage

@@ rtl/line_segment_rect_clipper.sv @@
`timescale 1ns / 1ps
// Top level of the Cohen-Sutherland line segment clipper.
//
// One item on the input channel is a segment with two endpoints. The block
// answers each item with exactly one item on the output channel: the clipped
// segment with visible set, or the input coordinates with visible clear when
// the segment misses the rectangle or the clip step limit is reached. The
// rectangle comes from four registers on the write port, which the user must
// write only while the block is idle; the block does not enforce this. An
// unclipped segment goes from EVAL to the output register. Each clip step
// runs the outcode test and operand setup in EVAL, NUM, DEN, TDIST and CALL,
// then the shared divider and multiplier (56 quotient bits and 40 multiplier
// bits, one per cycle, then a result state). At most 8 clip steps run and the
// input stalls meanwhile. A finished item waits in an output register; the
// next segment is taken while it waits, and its result is held back until
// the register is free. Reset empties the output register, stops any work in
// progress and restores the rectangle to origin 0,0 with size 640 by 480.
module line_segment_rect_clipper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lsrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lsrc_pkg::t_seg_in                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lsrc_pkg::t_seg_out                 o_out_data
);

    logic signed [lsrc_pkg::RECT_BITS-1:0] r_rect_left;
    logic signed [lsrc_pkg::RECT_BITS-1:0] r_rect_top;
    logic [lsrc_pkg::SIZE_BITS-1:0]        r_rect_width;
    logic [lsrc_pkg::SIZE_BITS-1:0]        r_rect_height;

    lsrc_pkg::t_cl_state r_state, n_state;
    logic                r_out_valid, n_out_valid;
    lsrc_pkg::t_seg_out  r_out, n_out;
    lsrc_pkg::t_seg_in   r_in, n_in;

    logic signed [lsrc_pkg::FXW-1:0] r_x0, n_x0, r_y0, n_y0;
    logic signed [lsrc_pkg::FXW-1:0] r_x1, n_x1, r_y1, n_y1;
    logic signed [lsrc_pkg::FXW-1:0] r_edge, n_edge;
    logic [lsrc_pkg::ITER_W-1:0]     r_iter, n_iter;
    logic                            r_first, n_first;
    logic                            r_axis_y, n_axis_y;
    logic [lsrc_pkg::MAGW-1:0]       r_nm, n_nm, r_dm, n_dm, r_tm, n_tm;
    logic                            r_neg, n_neg;

    logic signed [lsrc_pkg::EDGE_W-1:0] e_left, e_top, e_right, e_bottom;
    logic signed [lsrc_pkg::EDGE_W-1:0] e_right_clip, e_bottom_clip;
    logic [3:0]                         c0, c1, co;
    logic                               axis_y, fin, fin_vis;
    logic signed [lsrc_pkg::FXW-1:0]    a0, b0, a1, b1;
    logic signed [lsrc_pkg::FXW-1:0]    d_p, d_q, diff, step_s, b_sum, b_new;
    logic                               d_neg;
    logic [lsrc_pkg::MAGW-1:0]          d_mag;

    lsrc_pkg::t_du_req du_req;
    lsrc_pkg::t_du_rsp du_rsp;

    function automatic logic signed [lsrc_pkg::IPW-1:0] f_edge_ip(
        input logic signed [lsrc_pkg::EDGE_W-1:0] e
    );
        return $signed({{(lsrc_pkg::IPW-lsrc_pkg::EDGE_W){e[lsrc_pkg::EDGE_W-1]}}, e});
    endfunction

    function automatic logic signed [lsrc_pkg::FXW-1:0] f_edge_fx(
        input logic signed [lsrc_pkg::EDGE_W-1:0] e
    );
        return $signed({f_edge_ip(e), {lsrc_pkg::FRAC_BITS{1'b0}}});
    endfunction

    function automatic logic signed [lsrc_pkg::FXW-1:0] f_coord_fx(
        input logic signed [lsrc_pkg::COORD_BITS-1:0] c
    );
        return $signed({{(lsrc_pkg::IPW-lsrc_pkg::COORD_BITS){c[lsrc_pkg::COORD_BITS-1]}}, c,
                        {lsrc_pkg::FRAC_BITS{1'b0}}});
    endfunction

    // Truncation toward zero: a negative value with a fraction rounds up.
    function automatic logic [lsrc_pkg::COORD_BITS-1:0] f_fx_to_coord(
        input logic signed [lsrc_pkg::FXW-1:0] v
    );
        logic [lsrc_pkg::IPW-1:0] ip;
        ip = v[lsrc_pkg::FXW-1:lsrc_pkg::FRAC_BITS];
        if (v[lsrc_pkg::FXW-1] && (|v[lsrc_pkg::FRAC_BITS-1:0])) begin
            ip = ip + 1'b1;
        end
        return ip[lsrc_pkg::COORD_BITS-1:0];
    endfunction

    // The integer part alone decides the compare against an integer edge.
    function automatic logic [3:0] f_outcode(
        input logic signed [lsrc_pkg::FXW-1:0]    px,
        input logic signed [lsrc_pkg::FXW-1:0]    py,
        input logic signed [lsrc_pkg::EDGE_W-1:0] el,
        input logic signed [lsrc_pkg::EDGE_W-1:0] er,
        input logic signed [lsrc_pkg::EDGE_W-1:0] et,
        input logic signed [lsrc_pkg::EDGE_W-1:0] eb
    );
        logic signed [lsrc_pkg::IPW-1:0] xi;
        logic signed [lsrc_pkg::IPW-1:0] yi;
        logic [3:0]                      c;
        xi = px[lsrc_pkg::FXW-1:lsrc_pkg::FRAC_BITS];
        yi = py[lsrc_pkg::FXW-1:lsrc_pkg::FRAC_BITS];
        c  = '0;
        if (xi >= f_edge_ip(er)) begin
            c = c | lsrc_pkg::OC_RIGHT;
        end else if (xi < f_edge_ip(el)) begin
            c = c | lsrc_pkg::OC_LEFT;
        end
        if (yi >= f_edge_ip(eb)) begin
            c = c | lsrc_pkg::OC_BOTTOM;
        end else if (yi < f_edge_ip(et)) begin
            c = c | lsrc_pkg::OC_TOP;
        end
        return c;
    endfunction

    lsrc_divmul u_divmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .o_rsp   (du_rsp)
    );

    assign o_in_stall  = (r_state != lsrc_pkg::CL_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        du_req.start    = (r_state == lsrc_pkg::CL_CALL);
        du_req.num_mag  = r_nm;
        du_req.den_mag  = r_dm;
        du_req.offs_mag = r_tm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_width  <= lsrc_pkg::RST_WIDTH;
            r_rect_height <= lsrc_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsrc_pkg::CFG_LEFT:   r_rect_left   <= i_cfg_data[lsrc_pkg::RECT_BITS-1:0];
                lsrc_pkg::CFG_TOP:    r_rect_top    <= i_cfg_data[lsrc_pkg::RECT_BITS-1:0];
                lsrc_pkg::CFG_WIDTH:  r_rect_width  <= i_cfg_data[lsrc_pkg::SIZE_BITS-1:0];
                lsrc_pkg::CFG_HEIGHT: r_rect_height <= i_cfg_data[lsrc_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        e_left        = $signed({{(lsrc_pkg::EDGE_W-lsrc_pkg::RECT_BITS)
                                  {r_rect_left[lsrc_pkg::RECT_BITS-1]}}, r_rect_left});
        e_top         = $signed({{(lsrc_pkg::EDGE_W-lsrc_pkg::RECT_BITS)
                                  {r_rect_top[lsrc_pkg::RECT_BITS-1]}}, r_rect_top});
        e_right       = e_left + $signed({{(lsrc_pkg::EDGE_W-lsrc_pkg::SIZE_BITS){1'b0}},
                                          r_rect_width});
        e_bottom      = e_top + $signed({{(lsrc_pkg::EDGE_W-lsrc_pkg::SIZE_BITS){1'b0}},
                                         r_rect_height});
        e_right_clip  = e_right - lsrc_pkg::EDGE_ONE;
        e_bottom_clip = e_bottom - lsrc_pkg::EDGE_ONE;
        c0 = f_outcode(r_x0, r_y0, e_left, e_right, e_top, e_bottom);
        c1 = f_outcode(r_x1, r_y1, e_left, e_right, e_top, e_bottom);
    end

    // Operands of the current clip step: a runs along the clip edge's normal.
    always_comb begin
        a0 = r_axis_y ? r_y0 : r_x0;
        b0 = r_axis_y ? r_x0 : r_y0;
        a1 = r_axis_y ? r_y1 : r_x1;
        b1 = r_axis_y ? r_x1 : r_y1;
        case (r_state)
            lsrc_pkg::CL_NUM: begin
                d_p = b1;
                d_q = b0;
            end
            lsrc_pkg::CL_DEN: begin
                d_p = a1;
                d_q = a0;
            end
            default: begin
                d_p = r_edge;
                d_q = a0;
            end
        endcase
        diff   = d_p - d_q;
        d_neg  = diff[lsrc_pkg::FXW-1];
        d_mag  = d_neg ? -diff : diff;
        step_s = $signed(du_rsp.step_mag);
        b_sum  = r_neg ? (b0 - step_s) : (b0 + step_s);
        if (b_sum > $signed(lsrc_pkg::LIM)) begin
            b_new = $signed(lsrc_pkg::LIM);
        end else if (b_sum < -$signed(lsrc_pkg::LIM)) begin
            b_new = -$signed(lsrc_pkg::LIM);
        end else begin
            b_new = b_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsrc_pkg::CL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_in     <= n_in;
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_edge   <= n_edge;
        r_iter   <= n_iter;
        r_first  <= n_first;
        r_axis_y <= n_axis_y;
        r_nm     <= n_nm;
        r_dm     <= n_dm;
        r_tm     <= n_tm;
        r_neg    <= n_neg;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_in        = r_in;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_edge      = r_edge;
        n_iter      = r_iter;
        n_first     = r_first;
        n_axis_y    = r_axis_y;
        n_nm        = r_nm;
        n_dm        = r_dm;
        n_tm        = r_tm;
        n_neg       = r_neg;
        fin         = 1'b0;
        fin_vis     = 1'b0;
        co          = (c0 != '0) ? c0 : c1;
        axis_y      = ((co & (lsrc_pkg::OC_TOP | lsrc_pkg::OC_BOTTOM)) != '0);
        case (r_state)
            lsrc_pkg::CL_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_x0    = f_coord_fx(i_in_data.start_x);
                    n_y0    = f_coord_fx(i_in_data.start_y);
                    n_x1    = f_coord_fx(i_in_data.end_x);
                    n_y1    = f_coord_fx(i_in_data.end_y);
                    n_iter  = '0;
                    n_state = lsrc_pkg::CL_EVAL;
                end
            end
            lsrc_pkg::CL_EVAL: begin
                if (c0 == '0 && c1 == '0) begin
                    fin     = 1'b1;
                    fin_vis = 1'b1;
                end else if ((c0 & c1) != '0 || r_iter == lsrc_pkg::ITER_LAST) begin
                    fin = 1'b1;
                end else if (axis_y ? (r_y1 == r_y0) : (r_x1 == r_x0)) begin
                    fin = 1'b1;
                end else begin
                    n_first  = (c0 != '0);
                    n_axis_y = axis_y;
                    if ((co & lsrc_pkg::OC_TOP) != '0) begin
                        n_edge = f_edge_fx(e_top);
                    end else if ((co & lsrc_pkg::OC_BOTTOM) != '0) begin
                        n_edge = f_edge_fx(e_bottom_clip);
                    end else if ((co & lsrc_pkg::OC_RIGHT) != '0) begin
                        n_edge = f_edge_fx(e_right_clip);
                    end else begin
                        n_edge = f_edge_fx(e_left);
                    end
                    n_state = lsrc_pkg::CL_NUM;
                end
                if (fin && (!r_out_valid || !i_out_stall)) begin
                    n_out_valid   = 1'b1;
                    n_out.visible = fin_vis;
                    if (fin_vis) begin
                        n_out.clip_start_x = f_fx_to_coord(r_x0);
                        n_out.clip_start_y = f_fx_to_coord(r_y0);
                        n_out.clip_end_x   = f_fx_to_coord(r_x1);
                        n_out.clip_end_y   = f_fx_to_coord(r_y1);
                    end else begin
                        n_out.clip_start_x = r_in.start_x;
                        n_out.clip_start_y = r_in.start_y;
                        n_out.clip_end_x   = r_in.end_x;
                        n_out.clip_end_y   = r_in.end_y;
                    end
                    n_state = lsrc_pkg::CL_IDLE;
                end
            end
            lsrc_pkg::CL_NUM: begin
                n_nm    = d_mag;
                n_neg   = d_neg;
                n_state = lsrc_pkg::CL_DEN;
            end
            lsrc_pkg::CL_DEN: begin
                n_dm    = d_mag;
                n_neg   = r_neg ^ d_neg;
                n_state = lsrc_pkg::CL_TDIST;
            end
            lsrc_pkg::CL_TDIST: begin
                n_tm    = d_mag;
                n_neg   = r_neg ^ d_neg;
                n_state = lsrc_pkg::CL_CALL;
            end
            lsrc_pkg::CL_CALL: begin
                n_state = lsrc_pkg::CL_WAIT;
            end
            lsrc_pkg::CL_WAIT: begin
                if (du_rsp.done) begin
                    if (r_first) begin
                        n_x0 = r_axis_y ? b_new : r_edge;
                        n_y0 = r_axis_y ? r_edge : b_new;
                    end else begin
                        n_x1 = r_axis_y ? b_new : r_edge;
                        n_y1 = r_axis_y ? r_edge : b_new;
                    end
                    n_iter  = r_iter + 1'b1;
                    n_state = lsrc_pkg::CL_EVAL;
                end
            end
            default: begin
                n_state = lsrc_pkg::CL_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/lsrc_divmul.sv @@
`timescale 1ns / 1ps
// Iterative slope divider and offset multiplier built around one shared adder.
module lsrc_divmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsrc_pkg::t_du_req i_req,
    output lsrc_pkg::t_du_rsp o_rsp
);

    lsrc_pkg::t_du_state r_state, n_state;

    logic [lsrc_pkg::ACCW-1:0]   r_acc, n_acc;
    logic [lsrc_pkg::SLOPEW-1:0] r_quo, n_quo;
    logic [lsrc_pkg::MAGW-1:0]   r_den, n_den;
    logic [lsrc_pkg::MAGW-1:0]   r_mul, n_mul;
    logic [lsrc_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic [lsrc_pkg::ADDW-1:0]   add_a;
    logic [lsrc_pkg::ADDW-1:0]   add_b;
    logic [lsrc_pkg::ADDW-1:0]   add_sum;
    logic                        add_sub;
    logic [lsrc_pkg::MAGW:0]     rem_sh;
    logic [lsrc_pkg::PRODW-1:0]  prod;
    logic                        prod_sat;

    // The one adder: subtracts the divisor while dividing, adds the slope while multiplying.
    assign add_sum = add_a + (add_sub ? ~add_b : add_b)
                     + {{(lsrc_pkg::ADDW-1){1'b0}}, add_sub};

    assign rem_sh = {r_acc[lsrc_pkg::MAGW-1:0], r_quo[lsrc_pkg::SLOPEW-1]};

    assign prod     = {r_acc, r_mul};
    assign prod_sat = |prod[lsrc_pkg::PRODW-1:lsrc_pkg::LIM_BITS+lsrc_pkg::FRAC_BITS];

    always_comb begin
        o_rsp.done     = (r_state == lsrc_pkg::DU_DONE);
        o_rsp.step_mag = prod_sat ? lsrc_pkg::LIM :
                         {{(lsrc_pkg::MAGW-lsrc_pkg::LIM_BITS){1'b0}},
                          prod[lsrc_pkg::LIM_BITS+lsrc_pkg::FRAC_BITS-1:lsrc_pkg::FRAC_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsrc_pkg::DU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_den <= n_den;
        r_mul <= n_mul;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_den   = r_den;
        n_mul   = r_mul;
        n_cnt   = r_cnt;
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            lsrc_pkg::DU_IDLE: begin
                if (i_req.start) begin
                    n_acc   = '0;
                    n_quo   = {i_req.num_mag, {lsrc_pkg::FRAC_BITS{1'b0}}};
                    n_den   = i_req.den_mag;
                    n_mul   = i_req.offs_mag;
                    n_cnt   = '0;
                    n_state = lsrc_pkg::DU_DIV;
                end
            end
            lsrc_pkg::DU_DIV: begin
                add_a   = {{(lsrc_pkg::ADDW-lsrc_pkg::MAGW-1){1'b0}}, rem_sh};
                add_b   = {{(lsrc_pkg::ADDW-lsrc_pkg::MAGW){1'b0}}, r_den};
                add_sub = 1'b1;
                if (add_sum[lsrc_pkg::ADDW-1]) begin
                    n_acc = {{(lsrc_pkg::ACCW-lsrc_pkg::MAGW-1){1'b0}}, rem_sh};
                end else begin
                    n_acc = add_sum[lsrc_pkg::ACCW-1:0];
                end
                n_quo = {r_quo[lsrc_pkg::SLOPEW-2:0], ~add_sum[lsrc_pkg::ADDW-1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lsrc_pkg::DIV_LAST) begin
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = lsrc_pkg::DU_MUL;
                end
            end
            lsrc_pkg::DU_MUL: begin
                add_a = {1'b0, r_acc};
                add_b = r_mul[0] ? {2'b00, r_quo} : '0;
                n_acc = add_sum[lsrc_pkg::ADDW-1:1];
                n_mul = {add_sum[0], r_mul[lsrc_pkg::MAGW-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lsrc_pkg::MUL_LAST) begin
                    n_state = lsrc_pkg::DU_DONE;
                end
            end
            lsrc_pkg::DU_DONE: begin
                n_state = lsrc_pkg::DU_IDLE;
            end
            default: begin
                n_state = lsrc_pkg::DU_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/lsrc_checker.sv @@
`timescale 1ns / 1ps
// Port checker of the line segment clipper and its bind to the top level.
module lsrc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lsrc_pkg::t_seg_out o_out_data
);

    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       take_in;
    logic       take_out;

    assign take_in  = i_in_valid && !o_in_stall;
    assign take_out = o_out_valid && !i_out_stall;

    always_comb begin
        n_pend = r_pend + {1'b0, take_in} - {1'b0, take_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> o_in_stall)
        else $error("input was not stalled after an item was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output item changed or vanished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty and ready after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != 2'd0))
        else $error("output item without a pending input item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two items held inside the block");

endmodule

bind line_segment_rect_clipper lsrc_checker u_lsrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
